// File: hdl/sspi_pkg.sv
package sspi_pkg;

    // Table geometry
    localparam int MAX_POINTS  = 32;
    localparam int INNER_DEPTH = MAX_POINTS - 2;
    localparam int INNER_AW    = $clog2(INNER_DEPTH);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int DEN_W       = $clog2(MAX_POINTS);

    // Field widths
    localparam int ORDER_W  = 32;
    localparam int LOC_W    = 32;
    localparam int SPAN_W   = LOC_W + 1;
    localparam int DIV_CNT_W = $clog2(SPAN_W);
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 5;
    localparam int TOTAL_W  = 6;
    localparam int CFG_IDX_W = 2;

    // Sentinels held at both ends of the table
    localparam logic [ORDER_W-1:0] ORDER_MIN = {1'b1, {(ORDER_W-1){1'b0}}};
    localparam logic [ORDER_W-1:0] ORDER_MAX = {1'b0, {(ORDER_W-1){1'b1}}};

    // Status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;

    // Reset values of the scale bounds, Q16.16
    localparam logic [LOC_W-1:0] LOWER_RESET = 32'h0000_0000;
    localparam logic [LOC_W-1:0] UPPER_RESET = 32'h0001_0000;

endpackage

// File: hdl/sorted_scale_point_insert_unit.sv
// Sorted scale point table. Pulse start while busy is low to offer new_order; the
// transaction is taken at that edge and busy rises. The value is inserted in sorted
// position (status inserted), ignored if already present or equal to a sentinel
// (status duplicate), or rejected when all points are in use (status full). Every
// point of the table is then emitted in ascending order, each on the result ports
// for exactly one cycle with result_strobe high; last_point marks the final one.
// Results cannot be stalled, so the receiver must take each one in the cycle it
// appears. The last result shows in the same cycle in which busy falls. The
// inner table sits in a memory with one write port and one registered read port,
// walked one entry at a time for the search, the shift and the readout, and the
// point spacing comes from a bit-serial divider that retires one quotient bit
// per cycle. The scale bounds must be written through cfg_we / cfg_index /
// cfg_data only while busy is low and no result is pending; the block itself
// does not enforce this. The values in place when the transaction is taken
// apply to all locations of the run.
module sorted_scale_point_insert_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sspi_pkg::ORDER_W-1:0] new_order,
    input  logic                                cfg_we,
    input  logic [sspi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sspi_pkg::LOC_W-1:0]          cfg_data,
    output logic                                result_strobe,
    output logic [sspi_pkg::STATUS_W-1:0]       status,
    output logic [sspi_pkg::INDEX_W-1:0]        point_index,
    output logic signed [sspi_pkg::ORDER_W-1:0] point_order,
    output logic signed [sspi_pkg::LOC_W-1:0]   point_location,
    output logic [sspi_pkg::TOTAL_W-1:0]        point_total,
    output logic                                last_point
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SCAN_RD  = 11'b000_0000_0010,
        S_SCAN_CMP = 11'b000_0000_0100,
        S_DECIDE   = 11'b000_0000_1000,
        S_SHIFT_RD = 11'b000_0001_0000,
        S_SHIFT_WR = 11'b000_0010_0000,
        S_INSERT   = 11'b000_0100_0000,
        S_DIV_INIT = 11'b000_1000_0000,
        S_DIV      = 11'b001_0000_0000,
        S_EMIT_RD  = 11'b010_0000_0000,
        S_EMIT_OUT = 11'b100_0000_0000
    } state_t;

    // Inner points only; the two sentinels never move, so they live in no storage.
    logic [sspi_pkg::ORDER_W-1:0] mem [0:sspi_pkg::INNER_DEPTH-1];
    logic signed [sspi_pkg::ORDER_W-1:0] rd_data_reg;
    logic [sspi_pkg::INNER_AW-1:0] rd_addr;
    logic [sspi_pkg::INNER_AW-1:0] wr_addr;
    logic [sspi_pkg::ORDER_W-1:0]  wr_data;
    logic                          wr_en;

    state_t state_reg, state_next;
    logic [sspi_pkg::CNT_W-1:0] count_reg, count_next;
    logic signed [sspi_pkg::ORDER_W-1:0] v_reg, v_next;
    logic dup_reg, dup_next;
    logic [sspi_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [sspi_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [sspi_pkg::CNT_W-1:0] ins_reg, ins_next;
    logic neg_reg, neg_next;
    logic [sspi_pkg::SPAN_W-1:0] dq_reg, dq_next;
    logic [sspi_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [sspi_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [sspi_pkg::SPAN_W-1:0] acc_q_reg, acc_q_next;
    logic [sspi_pkg::DEN_W-1:0] acc_r_reg, acc_r_next;
    logic signed [sspi_pkg::LOC_W-1:0] lower_reg, upper_reg;

    logic strobe_reg, strobe_next;
    logic last_reg, last_next;
    logic [sspi_pkg::INDEX_W-1:0] pidx_reg, pidx_next;
    logic [sspi_pkg::ORDER_W-1:0] porder_reg, porder_next;
    logic [sspi_pkg::LOC_W-1:0] ploc_reg, ploc_next;

    // Derived values
    logic [sspi_pkg::CNT_W-1:0] inner_n;
    logic [sspi_pkg::CNT_W-1:0] den_full;
    logic [sspi_pkg::DEN_W-1:0] den;
    logic [sspi_pkg::SPAN_W-1:0] span;
    logic [sspi_pkg::DEN_W:0] div_trial;
    logic [sspi_pkg::DEN_W:0] r_sum;
    logic [sspi_pkg::SPAN_W:0] acc_signed;
    logic [sspi_pkg::SPAN_W:0] loc_sum;
    logic [sspi_pkg::CNT_W-1:0] idx_dec;
    logic [sspi_pkg::CNT_W-1:0] idx_inc;

    assign inner_n  = count_reg - sspi_pkg::CNT_W'(2);
    assign den_full = count_reg - sspi_pkg::CNT_W'(1);
    assign den      = den_full[sspi_pkg::DEN_W-1:0];
    assign span     = {upper_reg[sspi_pkg::LOC_W-1], upper_reg}
                    - {lower_reg[sspi_pkg::LOC_W-1], lower_reg};
    assign div_trial = {rem_reg, dq_reg[sspi_pkg::SPAN_W-1]};
    assign r_sum     = {1'b0, acc_r_reg} + {1'b0, rem_reg};
    assign acc_signed = neg_reg ? (~{1'b0, acc_q_reg} + 1'b1) : {1'b0, acc_q_reg};
    assign loc_sum   = {{2{lower_reg[sspi_pkg::LOC_W-1]}}, lower_reg} + acc_signed;
    assign idx_dec   = idx_reg - sspi_pkg::CNT_W'(1);
    assign idx_inc   = idx_reg + sspi_pkg::CNT_W'(1);

    assign busy           = (state_reg != S_IDLE);
    assign result_strobe  = strobe_reg;
    assign status         = status_reg;
    assign point_index    = pidx_reg;
    assign point_order    = porder_reg;
    assign point_location = ploc_reg;
    assign point_total    = count_reg;
    assign last_point     = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        v_next      = v_reg;
        dup_next    = dup_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        ins_next    = ins_reg;
        neg_next    = neg_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        acc_q_next  = acc_q_reg;
        acc_r_next  = acc_r_reg;
        strobe_next = 1'b0;
        last_next   = last_reg;
        pidx_next   = pidx_reg;
        porder_next = porder_reg;
        ploc_next   = ploc_reg;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = ins_reg[sspi_pkg::INNER_AW-1:0];
        wr_data     = v_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    v_next   = new_order;
                    // Sentinel values always match an end point.
                    dup_next = (new_order == sspi_pkg::ORDER_MIN)
                            || (new_order == sspi_pkg::ORDER_MAX);
                    ins_next = '0;
                    idx_next = '0;
                    state_next = (inner_n == '0) ? S_DECIDE : S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                rd_addr    = idx_reg[sspi_pkg::INNER_AW-1:0];
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (v_reg > rd_data_reg)
                    ins_next = idx_inc;
                else if (v_reg == rd_data_reg)
                    dup_next = 1'b1;
                idx_next   = idx_inc;
                state_next = (idx_inc == inner_n) ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE:
            begin
                if (dup_reg)
                begin
                    status_next = sspi_pkg::ST_DUPLICATE;
                    state_next  = S_DIV_INIT;
                end
                else if (count_reg == sspi_pkg::CNT_W'(sspi_pkg::MAX_POINTS))
                begin
                    status_next = sspi_pkg::ST_FULL;
                    state_next  = S_DIV_INIT;
                end
                else
                begin
                    status_next = sspi_pkg::ST_INSERTED;
                    idx_next    = inner_n;
                    state_next  = (inner_n > ins_reg) ? S_SHIFT_RD : S_INSERT;
                end
            end
            S_SHIFT_RD:
            begin
                rd_addr    = idx_dec[sspi_pkg::INNER_AW-1:0];
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                // Move one entry up, walking down toward the insert position.
                wr_en      = 1'b1;
                wr_addr    = idx_reg[sspi_pkg::INNER_AW-1:0];
                wr_data    = rd_data_reg;
                idx_next   = idx_dec;
                state_next = (idx_dec == ins_reg) ? S_INSERT : S_SHIFT_RD;
            end
            S_INSERT:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + sspi_pkg::CNT_W'(1);
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                neg_next   = span[sspi_pkg::SPAN_W-1];
                dq_next    = span[sspi_pkg::SPAN_W-1] ? (~span + 1'b1) : span;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // One restoring step: retire one quotient bit.
                if (div_trial >= {1'b0, den})
                begin
                    rem_next = sspi_pkg::DEN_W'(div_trial - {1'b0, den});
                    dq_next  = {dq_reg[sspi_pkg::SPAN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_trial[sspi_pkg::DEN_W-1:0];
                    dq_next  = {dq_reg[sspi_pkg::SPAN_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + sspi_pkg::DIV_CNT_W'(1);
                if (cnt_reg == sspi_pkg::DIV_CNT_W'(sspi_pkg::SPAN_W - 1))
                begin
                    acc_q_next = '0;
                    acc_r_next = '0;
                    idx_next   = '0;
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                if (idx_reg != '0 && idx_reg != den_full)
                    rd_addr = idx_dec[sspi_pkg::INNER_AW-1:0];
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                strobe_next = 1'b1;
                pidx_next   = idx_reg[sspi_pkg::INDEX_W-1:0];
                last_next   = (idx_reg == den_full);
                if (idx_reg == '0)
                    porder_next = sspi_pkg::ORDER_MIN;
                else if (idx_reg == den_full)
                    porder_next = sspi_pkg::ORDER_MAX;
                else
                    porder_next = rd_data_reg;
                ploc_next = loc_sum[sspi_pkg::LOC_W-1:0];
                // Advance floor(index * |span| / den) by quotient and remainder.
                if (r_sum >= {1'b0, den})
                begin
                    acc_r_next = sspi_pkg::DEN_W'(r_sum - {1'b0, den});
                    acc_q_next = acc_q_reg + dq_reg + sspi_pkg::SPAN_W'(1);
                end
                else
                begin
                    acc_r_next = r_sum[sspi_pkg::DEN_W-1:0];
                    acc_q_next = acc_q_reg + dq_reg;
                end
                idx_next   = idx_inc;
                state_next = (idx_reg == den_full) ? S_IDLE : S_EMIT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= sspi_pkg::CNT_W'(2);
            strobe_reg <= 1'b0;
            lower_reg  <= sspi_pkg::LOWER_RESET;
            upper_reg  <= sspi_pkg::UPPER_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sspi_pkg::CFG_LOWER: lower_reg <= cfg_data;
                    sspi_pkg::CFG_UPPER: upper_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        dup_reg    <= dup_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        ins_reg    <= ins_next;
        neg_reg    <= neg_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        acc_q_reg  <= acc_q_next;
        acc_r_reg  <= acc_r_next;
        last_reg   <= last_next;
        pidx_reg   <= pidx_next;
        porder_reg <= porder_next;
        ploc_reg   <= ploc_next;
    end

    // Inner point memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// File: hdl/sspi_checker.sv
module sspi_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               result_strobe,
    input logic [sspi_pkg::STATUS_W-1:0]      status,
    input logic [sspi_pkg::INDEX_W-1:0]       point_index,
    input logic [sspi_pkg::ORDER_W-1:0]       point_order,
    input logic [sspi_pkg::TOTAL_W-1:0]       point_total,
    input logic                               last_point
);

    // A run of results steps through the table one index at a time.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_point |-> ##2 (result_strobe
            && point_index == $past(point_index, 2) + 5'd1))
        else $error("result run broke off or skipped an index");

    // The first point is the lower sentinel.
    a_first_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && point_index == '0 |-> point_order == sspi_pkg::ORDER_MIN)
        else $error("first point is not the lower sentinel");

    // The final point is the upper sentinel and closes the count.
    a_last_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last_point |->
            (point_order == sspi_pkg::ORDER_MAX
            && point_total[sspi_pkg::INDEX_W-1:0] == point_index + 5'd1))
        else $error("last point does not close the table");

    // Status stays within its codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (status == sspi_pkg::ST_INSERTED
            || status == sspi_pkg::ST_DUPLICATE || status == sspi_pkg::ST_FULL))
        else $error("status code out of range");

    // An accepted transaction keeps the unit busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transaction accepted without going busy");

endmodule

bind sorted_scale_point_insert_unit sspi_checker u_sspi_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .result_strobe  (result_strobe),
    .status         (status),
    .point_index    (point_index),
    .point_order    (point_order),
    .point_total    (point_total),
    .last_point     (last_point)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Register indexes beyond the two scale bounds; the block must ignore them
    localparam logic [sspi_pkg::CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
    localparam logic [sspi_pkg::CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

    // Extreme Q16.16 scale bounds
    localparam logic [sspi_pkg::LOC_W-1:0] LOC_MOST_NEG = 32'h8000_0000;
    localparam logic [sspi_pkg::LOC_W-1:0] LOC_MOST_POS = 32'h7FFF_FFFF;

    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int TAIL_CYCLES     = 60;

    // What the driver does with the head of its pending queue
    typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} action_t;

    typedef struct {
        action_t          kind;
        logic [1:0]       index;
        logic [31:0]      value;
        bit               may_idle;
    } stim_t;

    // One emitted point as the block should present it
    typedef struct {
        logic [sspi_pkg::STATUS_W-1:0] status;
        logic [sspi_pkg::INDEX_W-1:0]  index;
        logic [sspi_pkg::ORDER_W-1:0]  order;
        logic [sspi_pkg::LOC_W-1:0]    location;
        logic [sspi_pkg::TOTAL_W-1:0]  total;
        logic                          is_last;
    } point_t;

    // Clock, reset and DUT ports; every input starts at a known value
    logic                                clk;
    logic                                rst_n;
    logic                                start     = 1'b0;
    logic                                busy;
    logic signed [sspi_pkg::ORDER_W-1:0] new_order = '0;
    logic                                cfg_we    = 1'b0;
    logic [sspi_pkg::CFG_IDX_W-1:0]      cfg_index = sspi_pkg::CFG_LOWER;
    logic [sspi_pkg::LOC_W-1:0]          cfg_data  = '0;
    logic                                result_strobe;
    logic [sspi_pkg::STATUS_W-1:0]       status;
    logic [sspi_pkg::INDEX_W-1:0]        point_index;
    logic signed [sspi_pkg::ORDER_W-1:0] point_order;
    logic signed [sspi_pkg::LOC_W-1:0]   point_location;
    logic [sspi_pkg::TOTAL_W-1:0]        point_total;
    logic                                last_point;

    // Shadow of the block: sorted table, point count and scale bounds
    logic signed [sspi_pkg::ORDER_W-1:0] sorted_orders [sspi_pkg::MAX_POINTS];
    int                                  point_cnt;
    logic signed [sspi_pkg::LOC_W-1:0]   scale_lower_q;
    logic signed [sspi_pkg::LOC_W-1:0]   scale_upper_q;

    stim_t                               pending_ops [$];
    point_t                              expected_points [$];
    logic [31:0]                         offered [$];

    // Driver scratch
    logic                                took;
    logic                                nx_start;
    logic                                nx_cfg_we;
    logic [sspi_pkg::ORDER_W-1:0]        nx_order;
    logic [sspi_pkg::CFG_IDX_W-1:0]      nx_index;
    logic [sspi_pkg::LOC_W-1:0]          nx_data;
    int                                  gap_left;

    point_t                              want_pt;

    int                                  errors;
    int                                  items_taken;
    int                                  points_checked;
    int                                  cfg_writes;
    int                                  n_inserted;
    int                                  n_duplicate;
    int                                  n_full;

    sorted_scale_point_insert_unit u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .new_order      (new_order),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_strobe  (result_strobe),
        .status         (status),
        .point_index    (point_index),
        .point_order    (point_order),
        .point_location (point_location),
        .point_total    (point_total),
        .last_point     (last_point)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hold reset once, at the start of the run
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Table state right after reset: the two sentinels and the default scale
    initial
    begin
        sorted_orders[0] = sspi_pkg::ORDER_MIN;
        sorted_orders[1] = sspi_pkg::ORDER_MAX;
        for (int i = 2; i < sspi_pkg::MAX_POINTS; i++)
            sorted_orders[i] = '0;
        point_cnt     = 2;
        scale_lower_q = sspi_pkg::LOWER_RESET;
        scale_upper_q = sspi_pkg::UPPER_RESET;
        gap_left      = 0;
        errors        = 0;
        items_taken   = 0;
        points_checked = 0;
        cfg_writes    = 0;
        n_inserted    = 0;
        n_duplicate   = 0;
        n_full        = 0;
    end

    // Offer one order value to the shadow table and queue every point that
    // the block must emit for it. Locations use the bounds in place now.
    task automatic insert_and_expect(input logic signed [sspi_pkg::ORDER_W-1:0] order_val);
        int                            p;
        int                            ins_pos;
        bit                            dup;
        logic [sspi_pkg::STATUS_W-1:0] st;
        longint                        span;
        longint                        den;
        longint                        loc;
        point_t                        pt;
        begin
            ins_pos = 0;
            dup     = 1'b0;
            for (p = 0; p < point_cnt; p++)
            begin
                if (order_val > sorted_orders[p])
                    ins_pos = p + 1;
                else if (order_val == sorted_orders[p])
                    dup = 1'b1;
            end

            if (dup)
            begin
                st = sspi_pkg::ST_DUPLICATE;
                n_duplicate++;
            end
            else if (point_cnt >= sspi_pkg::MAX_POINTS)
            begin
                st = sspi_pkg::ST_FULL;
                n_full++;
            end
            else
            begin
                // Open a slot at the insert position by moving the tail up one
                for (p = point_cnt; p > ins_pos; p--)
                    sorted_orders[p] = sorted_orders[p-1];
                sorted_orders[ins_pos] = order_val;
                point_cnt++;
                st = sspi_pkg::ST_INSERTED;
                n_inserted++;
            end

            // Exact 64-bit spacing; SystemVerilog division truncates toward zero
            span = longint'(scale_upper_q) - longint'(scale_lower_q);
            den  = point_cnt - 1;
            for (p = 0; p < point_cnt; p++)
            begin
                loc         = longint'(scale_lower_q) + (longint'(p) * span) / den;
                pt.status   = st;
                pt.index    = p[sspi_pkg::INDEX_W-1:0];
                pt.order    = sorted_orders[p];
                pt.location = loc[sspi_pkg::LOC_W-1:0];
                pt.total    = point_cnt[sspi_pkg::TOTAL_W-1:0];
                pt.is_last  = (p == point_cnt - 1);
                expected_points.push_back(pt);
            end
        end
    endtask

    task automatic apply_cfg(input logic [sspi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sspi_pkg::LOC_W-1:0] val);
        begin
            if (idx == sspi_pkg::CFG_LOWER)
                scale_lower_q = val;
            else if (idx == sspi_pkg::CFG_UPPER)
                scale_upper_q = val;
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        begin
            if (want_v !== got_v)
            begin
                $display("%0t: %s mismatch: expected 0x%h actual 0x%h",
                         $time, what, want_v, got_v);
                errors++;
            end
        end
    endtask

    task automatic push_item(input logic [31:0] val, input bit may_idle);
        stim_t s;
        begin
            s.kind     = ACT_ITEM;
            s.index    = sspi_pkg::CFG_LOWER;
            s.value    = val;
            s.may_idle = may_idle;
            pending_ops.push_back(s);
            offered.push_back(val);
        end
    endtask

    task automatic push_cfg(input logic [sspi_pkg::CFG_IDX_W-1:0] idx,
                            input logic [sspi_pkg::LOC_W-1:0] val);
        stim_t s;
        begin
            s.kind     = ACT_CFG;
            s.index    = idx;
            s.value    = val;
            s.may_idle = 1'b0;
            pending_ops.push_back(s);
        end
    endtask

    // Pause the sender until every outstanding point has been seen
    task automatic push_drain();
        stim_t s;
        begin
            s.kind     = ACT_DRAIN;
            s.index    = sspi_pkg::CFG_LOWER;
            s.value    = '0;
            s.may_idle = 1'b0;
            pending_ops.push_back(s);
        end
    endtask

    // Pick a random order value: mostly fresh, some repeats, sentinels and
    // values around zero so duplicates keep showing up once the table fills.
    function automatic logic [31:0] pick_order();
        int mode;
        begin
            mode = $urandom_range(0, 9);
            if (mode <= 5 || offered.size() == 0)
                return $urandom();
            else if (mode <= 7)
                return offered[$urandom_range(0, offered.size() - 1)];
            else if (mode == 8)
                return 32'($signed($urandom_range(0, 64)) - 32);
            else
                return ($urandom_range(0, 1) != 0) ? sspi_pkg::ORDER_MIN
                                                   : sspi_pkg::ORDER_MAX;
        end
    endfunction

    // Driver: hold start until the transaction is taken (start high, busy low),
    // then advance to the next pending entry. Register writes and drains only
    // go out while the block is idle with nothing left outstanding.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            new_order <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= sspi_pkg::CFG_LOWER;
            cfg_data  <= '0;
        end
        else
        begin
            took = start && !busy;
            if (took)
            begin
                insert_and_expect(new_order);
                items_taken++;
            end

            nx_start  = start && !took;
            nx_cfg_we = 1'b0;
            nx_order  = nx_start ? new_order : $urandom();
            nx_index  = 2'($urandom_range(0, 3));
            nx_data   = $urandom();

            if (!nx_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_ops.size() > 0)
                begin
                    case (pending_ops[0].kind)
                        ACT_ITEM:
                        begin
                            nx_start = 1'b1;
                            nx_order = pending_ops[0].value;
                            // Idle in bursts; the gap lands before the next entry
                            if (pending_ops[0].may_idle && $urandom_range(0, 2) == 0)
                                gap_left = $urandom_range(1, 13);
                            void'(pending_ops.pop_front());
                        end
                        default:
                        begin
                            if (!took && !busy && expected_points.size() == 0)
                            begin
                                if (pending_ops[0].kind == ACT_CFG)
                                begin
                                    nx_cfg_we = 1'b1;
                                    nx_index  = pending_ops[0].index;
                                    nx_data   = pending_ops[0].value;
                                    apply_cfg(nx_index, nx_data);
                                    cfg_writes++;
                                end
                                void'(pending_ops.pop_front());
                            end
                        end
                    endcase
                end
            end

            start     <= nx_start;
            new_order <= nx_order;
            cfg_we    <= nx_cfg_we;
            cfg_index <= nx_index;
            cfg_data  <= nx_data;
        end
    end

    // Monitor: every strobed result is one point out; compare it with
    // the oldest expected point, field by field.
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected point: expected none, actual index %0d order 0x%h",
                         $time, point_index, point_order);
                errors++;
            end
            else
            begin
                want_pt = expected_points.pop_front();
                check_field("status", want_pt.status, status);
                check_field("point_index", want_pt.index, point_index);
                check_field("point_order", want_pt.order, point_order);
                check_field("point_location", want_pt.location, point_location);
                check_field("point_total", want_pt.total, point_total);
                check_field("last_point", want_pt.is_last, last_point);
                points_checked++;
            end
        end
    end

    // Stimulus plan, end of run and verdict
    initial
    begin
        logic [sspi_pkg::LOC_W-1:0] lo;
        logic [sspi_pkg::LOC_W-1:0] hi;

        // Default scale: zero, both sentinels, a repeat, values around zero
        push_item(32'h0000_0000, 1'b1);
        push_item(sspi_pkg::ORDER_MIN, 1'b1);
        push_item(sspi_pkg::ORDER_MAX, 1'b1);
        push_item(32'h0000_0000, 1'b1);
        push_item(32'hFFFF_FFFF, 1'b1);
        push_item(32'h0000_0001, 1'b1);
        push_drain();

        // Widest span; orders next to the sentinels and alternating bit patterns
        push_cfg(sspi_pkg::CFG_LOWER, LOC_MOST_NEG);
        push_cfg(sspi_pkg::CFG_UPPER, LOC_MOST_POS);
        push_item(32'h7FFF_FFFE, 1'b0);
        push_item(32'h8000_0001, 1'b0);
        push_item(32'h5555_5555, 1'b0);
        push_item(32'hAAAA_AAAA, 1'b0);
        push_drain();

        // Lower above upper: locations run downward. Spare indexes must not stick.
        push_cfg(sspi_pkg::CFG_LOWER, LOC_MOST_POS);
        push_cfg(sspi_pkg::CFG_UPPER, LOC_MOST_NEG);
        push_cfg(CFG_SPARE2, 32'h0000_0000);
        push_cfg(CFG_SPARE3, 32'hFFFF_FFFF);
        push_item(32'h0001_0000, 1'b1);
        push_item(32'hFFFF_0000, 1'b1);
        push_item(32'h7FFF_FFFE, 1'b1);
        push_drain();

        // Zero span: every location equals the bound
        push_cfg(sspi_pkg::CFG_LOWER, 32'h1234_5678);
        push_cfg(sspi_pkg::CFG_UPPER, 32'h1234_5678);
        push_item(32'h0BAD_F00D, 1'b1);
        push_item(32'hF00D_0BAD, 1'b1);
        push_drain();

        // Random phases, each under its own scale; the last one runs with no idling
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    lo = $urandom();
                    hi = $urandom();
                end
                1:
                begin
                    lo = $urandom();
                    hi = $urandom();
                    if ($signed(lo) > $signed(hi))
                    begin
                        lo = lo ^ hi;
                        hi = lo ^ hi;
                        lo = lo ^ hi;
                    end
                end
                2:
                begin
                    lo = LOC_MOST_NEG;
                    hi = LOC_MOST_POS;
                end
                default:
                begin
                    lo = $urandom_range(0, 32'h7FFF_FFFF);
                    hi = -$urandom_range(0, 32'h7FFF_FFFF);
                end
            endcase
            push_cfg(sspi_pkg::CFG_LOWER, lo);
            push_cfg(sspi_pkg::CFG_UPPER, hi);
            if ($urandom_range(0, 1) != 0)
                push_cfg(($urandom_range(0, 1) != 0) ? CFG_SPARE2 : CFG_SPARE3, $urandom());

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                push_item(pick_order(), ph != RANDOM_PHASES - 1);
                // Drain now and then in the middle of a phase as well
                if ($urandom_range(0, 15) == 0)
                    push_drain();
            end
            push_drain();
        end

        // Wait for the stimulus to drain and every expected point to show up
        @(posedge rst_n);
        while (pending_ops.size() != 0 || start || expected_points.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_points.size() != 0)
        begin
            $display("%0t: %0d points still outstanding: expected 0 actual %0d",
                     $time, expected_points.size(), expected_points.size());
            errors++;
        end

        $display("Offered %0d orders (%0d inserted, %0d duplicate, %0d rejected full)",
                 items_taken, n_inserted, n_duplicate, n_full);
        $display("Checked %0d points across %0d register writes, %0d errors",
                 points_checked, cfg_writes, errors);

        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
